[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the packetizer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define RTPP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define RTPP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/rtpp_pkg.sv]
// ----------------------------------------------------------------------------
// rtpp_pkg
// constants and types of the partition packetizer
// ----------------------------------------------------------------------------
package rtpp_pkg;

   localparam int PAYLOAD_BYTES = 1400;
   localparam int HDR_BYTES     = 3;
   localparam int KEY_HDR_BYTES = 7;
   localparam int MAX_PKTS      = 64;
   localparam int TS_MULT       = 90;

   localparam int SEQ_W  = 16;
   localparam int TS_W   = 32;
   localparam int FSZ_W  = 20;
   localparam int PSZ_W  = 16;
   localparam int PID_W  = 4;
   localparam int LEN_W  = 11;
   // partition size plus the largest frame header
   localparam int SIZE_W = PSZ_W + 1;
   localparam int CNT_W  = $clog2(MAX_PKTS);

   localparam logic [SIZE_W-1:0] PAYLOAD_SZ  = SIZE_W'(PAYLOAD_BYTES);
   localparam logic [SIZE_W-1:0] HDR_SZ      = SIZE_W'(HDR_BYTES);
   localparam logic [SIZE_W-1:0] KEY_HDR_SZ  = SIZE_W'(HDR_BYTES + KEY_HDR_BYTES);
   localparam logic [CNT_W-1:0]  LAST_CNT    = CNT_W'(MAX_PKTS - 1);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } rtpp_state_type;

   typedef struct packed {
      logic load;   // capture the request
      logic whole;  // frame fits in one packet
      logic skip;   // tail of a fitted frame, nothing to send
      logic emit;   // load one packet into the output register
   } rtpp_cmd_type;

   typedef struct packed {
      logic frame_start;
      logic small_frame;
      logic fits;
      logic out_free;
      logic pkt_final;
   } rtpp_status_type;

endpackage

[rtl/rtp_partition_packetizer.sv]
// ----------------------------------------------------------------------------
// rtp_partition_packetizer
// cuts video frame partition descriptors into rtp packet descriptors
// ----------------------------------------------------------------------------
// each request describes one partition of a frame; part_index 0 opens a frame.
// a frame of up to 1400 bytes goes out whole as one marked packet on its first
// request, and its later requests produce no packet. otherwise the partition,
// plus the frame header on partition 0, is cut into 1400 byte packets, at most
// 64 per request; only the frame's final packet carries the marker.
// req_ready is high only while idle. a taken request is loaded into the
// request registers; a request that produces no packet leaves the block
// idle, else the sequencer goes on to load its packets in turn into the
// output register that drives rsp_valid. packets leave through one output
// register; while rsp_ready is low the packet holds and the sequencer waits,
// one packet per cycle again once the receiver takes them.
// csr_wr_en loads the sequence counter from csr_wr_data; write it only while
// idle. reset clears the sequence counter, the frame offset and the fitted
// frame flag, and empties the output register.
// ----------------------------------------------------------------------------
module rtp_partition_packetizer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rtpp_pkg::SEQ_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rtpp_pkg::TS_W-1:0]   req_pts,
   input  logic [rtpp_pkg::FSZ_W-1:0]  req_frame_size,
   input  logic [rtpp_pkg::PSZ_W-1:0]  req_part_size,
   input  logic [rtpp_pkg::PID_W-1:0]  req_part_index,
   input  logic                        req_last_part,
   input  logic                        req_keyframe,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rtpp_pkg::SEQ_W-1:0]  rsp_seq_num,
   output logic [rtpp_pkg::TS_W-1:0]   rsp_timestamp,
   output logic                        rsp_marker,
   output logic                        rsp_part_start,
   output logic [rtpp_pkg::PID_W-1:0]  rsp_part_id,
   output logic [rtpp_pkg::FSZ_W-1:0]  rsp_byte_offset,
   output logic [rtpp_pkg::LEN_W-1:0]  rsp_length,
   output logic                        rsp_last
);

   rtpp_pkg::rtpp_cmd_type    cmd;
   rtpp_pkg::rtpp_status_type status;

   rtpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rtpp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_pts         (req_pts),
      .req_frame_size  (req_frame_size),
      .req_part_size   (req_part_size),
      .req_part_index  (req_part_index),
      .req_last_part   (req_last_part),
      .req_keyframe    (req_keyframe),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_seq_num     (rsp_seq_num),
      .rsp_timestamp   (rsp_timestamp),
      .rsp_marker      (rsp_marker),
      .rsp_part_start  (rsp_part_start),
      .rsp_part_id     (rsp_part_id),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_length      (rsp_length),
      .rsp_last        (rsp_last)
   );

endmodule

[rtl/rtpp_ctrl.sv]
// ----------------------------------------------------------------------------
// rtpp_ctrl
// sequencer: takes a request, then issues one packet per free output slot
// ----------------------------------------------------------------------------
module rtpp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rtpp_pkg::rtpp_status_type status,
   output rtpp_pkg::rtpp_cmd_type    cmd
);

   rtpp_pkg::rtpp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtpp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         rtpp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.whole = status.frame_start && status.small_frame;
               cmd.skip  = !status.frame_start && status.fits;
               if (!cmd.skip) begin
                  state_in = rtpp_pkg::ST_EMIT;
               end
            end
         end
         rtpp_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.pkt_final) begin
                  state_in = rtpp_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rtpp_pkg::ST_IDLE;
         end
      endcase
   end

   `include "assert_macros.svh"

   `RTPP_ASSERT(a_no_emit_in_idle, clock, reset,
      (state_ff == rtpp_pkg::ST_IDLE) |-> !cmd.emit, "packet issued while idle")
   `RTPP_ASSERT(a_final_returns_idle, clock, reset,
      (cmd.emit && status.pkt_final) |=> req_ready, "not idle after the final packet")
   `RTPP_ASSERT(a_load_leaves_idle, clock, reset,
      (cmd.load && !cmd.skip) |=> !req_ready, "request taken without sending packets")

endmodule

[rtl/rtpp_datapath.sv]
// ----------------------------------------------------------------------------
// rtpp_datapath
// frame state, chunk cutter and output register of the packetizer
// ----------------------------------------------------------------------------
module rtpp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rtpp_pkg::SEQ_W-1:0]        csr_wr_data,
   input  logic [rtpp_pkg::TS_W-1:0]         req_pts,
   input  logic [rtpp_pkg::FSZ_W-1:0]        req_frame_size,
   input  logic [rtpp_pkg::PSZ_W-1:0]        req_part_size,
   input  logic [rtpp_pkg::PID_W-1:0]        req_part_index,
   input  logic                              req_last_part,
   input  logic                              req_keyframe,
   input  rtpp_pkg::rtpp_cmd_type            cmd,
   output rtpp_pkg::rtpp_status_type         status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rtpp_pkg::SEQ_W-1:0]        rsp_seq_num,
   output logic [rtpp_pkg::TS_W-1:0]         rsp_timestamp,
   output logic                              rsp_marker,
   output logic                              rsp_part_start,
   output logic [rtpp_pkg::PID_W-1:0]        rsp_part_id,
   output logic [rtpp_pkg::FSZ_W-1:0]        rsp_byte_offset,
   output logic [rtpp_pkg::LEN_W-1:0]        rsp_length,
   output logic                              rsp_last
);

   // frame state
   logic [rtpp_pkg::SEQ_W-1:0]  seq_ff;
   logic [rtpp_pkg::FSZ_W-1:0]  offset_ff;
   logic                        fits_ff;

   // current request
   logic [rtpp_pkg::TS_W-1:0]   ts_ff;
   logic [rtpp_pkg::SIZE_W-1:0] size_ff;
   logic [rtpp_pkg::PID_W-1:0]  pid_ff;
   logic                        marker_ff;
   logic                        pstart_ff;
   logic [rtpp_pkg::CNT_W-1:0]  count_ff;

   // output register
   logic                        out_valid_ff;
   logic [rtpp_pkg::SEQ_W-1:0]  out_seq_ff;
   logic [rtpp_pkg::TS_W-1:0]   out_ts_ff;
   logic                        out_marker_ff;
   logic                        out_pstart_ff;
   logic [rtpp_pkg::PID_W-1:0]  out_pid_ff;
   logic [rtpp_pkg::FSZ_W-1:0]  out_offset_ff;
   logic [rtpp_pkg::LEN_W-1:0]  out_len_ff;
   logic                        out_last_ff;

   logic                        frame_start;
   logic                        small_frame;
   logic                        pkt_final;
   logic [rtpp_pkg::SIZE_W-1:0] chunk_len;
   logic [rtpp_pkg::SIZE_W-1:0] part_total;

   assign frame_start = (req_part_index == '0);
   assign small_frame = (req_frame_size <= rtpp_pkg::FSZ_W'(rtpp_pkg::PAYLOAD_BYTES));
   assign part_total  = rtpp_pkg::SIZE_W'(req_part_size)
                      + (frame_start ? (req_keyframe ? rtpp_pkg::KEY_HDR_SZ
                                                     : rtpp_pkg::HDR_SZ) : '0);

   // last chunk of the partition, or the packet budget is used up
   assign pkt_final = (size_ff <= rtpp_pkg::PAYLOAD_SZ) || (count_ff == rtpp_pkg::LAST_CNT);
   assign chunk_len = (size_ff <= rtpp_pkg::PAYLOAD_SZ) ? size_ff : rtpp_pkg::PAYLOAD_SZ;

   assign status.frame_start = frame_start;
   assign status.small_frame = small_frame;
   assign status.fits        = fits_ff;
   assign status.out_free    = !out_valid_ff || rsp_ready;
   assign status.pkt_final   = pkt_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         offset_ff    <= '0;
         fits_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seq_ff <= csr_wr_data;
         end else if (cmd.emit) begin
            seq_ff <= seq_ff + 1'b1;
         end

         if (cmd.load) begin
            if (cmd.skip) begin
               if (req_last_part) begin
                  fits_ff <= 1'b0;
               end
            end else if (cmd.whole) begin
               fits_ff   <= !req_last_part;
               offset_ff <= '0;
            end else if (frame_start) begin
               fits_ff   <= 1'b0;
               offset_ff <= '0;
            end
         end else if (cmd.emit) begin
            offset_ff <= offset_ff + rtpp_pkg::FSZ_W'(chunk_len);
         end

         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // request and output payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ts_ff     <= rtpp_pkg::TS_W'(req_pts * rtpp_pkg::TS_W'(rtpp_pkg::TS_MULT));
         pstart_ff <= 1'b1;
         count_ff  <= '0;
         if (cmd.whole) begin
            size_ff   <= rtpp_pkg::SIZE_W'(req_frame_size);
            pid_ff    <= '0;
            marker_ff <= 1'b1;
         end else begin
            size_ff   <= part_total;
            pid_ff    <= req_part_index;
            marker_ff <= req_last_part;
         end
      end else if (cmd.emit) begin
         size_ff   <= size_ff - rtpp_pkg::PAYLOAD_SZ;
         pstart_ff <= 1'b0;
         count_ff  <= count_ff + 1'b1;
      end

      if (cmd.emit) begin
         out_seq_ff    <= seq_ff;
         out_ts_ff     <= ts_ff;
         out_marker_ff <= marker_ff && pkt_final;
         out_pstart_ff <= pstart_ff;
         out_pid_ff    <= pid_ff;
         out_offset_ff <= offset_ff;
         out_len_ff    <= rtpp_pkg::LEN_W'(chunk_len);
         out_last_ff   <= pkt_final;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_seq_num     = out_seq_ff;
   assign rsp_timestamp   = out_ts_ff;
   assign rsp_marker      = out_marker_ff;
   assign rsp_part_start  = out_pstart_ff;
   assign rsp_part_id     = out_pid_ff;
   assign rsp_byte_offset = out_offset_ff;
   assign rsp_length      = out_len_ff;
   assign rsp_last        = out_last_ff;

   `include "assert_macros.svh"

   `RTPP_ASSERT(a_emit_into_free_slot, clock, reset,
      cmd.emit |-> (!out_valid_ff || rsp_ready), "pending packet overwritten")
   `RTPP_ASSERT(a_seq_advances, clock, reset,
      (cmd.emit && !csr_wr_en) |=> (seq_ff == $past(seq_ff) + 1'b1),
      "sequence number did not advance")
   `RTPP_ASSERT(a_last_on_final, clock, reset,
      (cmd.emit && pkt_final) |=> (out_valid_ff && out_last_ff),
      "final packet not flagged last")
   `RTPP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !out_valid_ff, "output valid after reset")

endmodule
